@@ rtl/ptts_pkg.sv @@
package ptts_pkg;

   localparam int TASK_SLOTS   = 16;
   localparam int SLOT_W       = $clog2(TASK_SLOTS);
   localparam int MARK_W       = $clog2(TASK_SLOTS + 1);
   localparam int PRIO_W       = 8;
   localparam int WORD_W       = 32;
   localparam int OP_W         = 2;
   localparam int STAT_W       = 2;
   localparam int SLOT_FIELD_W = 4;

   localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
   localparam logic [OP_W-1:0] OP_EXIT   = 2'd1;
   localparam logic [OP_W-1:0] OP_YIELD  = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
   localparam logic [STAT_W-1:0] STAT_NONE = 2'd2;

   // one above any 8-bit priority: nothing found yet
   localparam logic [PRIO_W:0] NO_PRIO = {1'b1, {PRIO_W{1'b0}}};

   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic [WORD_W-1:0] entry;
      logic [WORD_W-1:0] arg;
   } task_rec_type;

   typedef struct packed {
      logic              wr_en;
      logic [SLOT_W-1:0] wr_addr;
      task_rec_type      wr_data;
      logic [SLOT_W-1:0] rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic [STAT_W-1:0]       status;
      logic [SLOT_FIELD_W-1:0] slot;
      logic [WORD_W-1:0]       run_entry;
      logic [WORD_W-1:0]       run_arg;
   } rsp_type;

endpackage

@@ rtl/ptts_req_if.sv @@
interface ptts_req_if import ptts_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [PRIO_W-1:0] priority_req;
   logic [WORD_W-1:0] entry_addr;
   logic [WORD_W-1:0] task_arg;

   modport source (output valid, op, priority_req, entry_addr, task_arg, input ready);
   modport sink (input valid, op, priority_req, entry_addr, task_arg, output ready);
endinterface

@@ rtl/ptts_rsp_if.sv @@
interface ptts_rsp_if import ptts_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [STAT_W-1:0]       status;
   logic [SLOT_FIELD_W-1:0] slot;
   logic [WORD_W-1:0]       run_entry;
   logic [WORD_W-1:0]       run_arg;

   modport source (output valid, status, slot, run_entry, run_arg, input ready);
   modport sink (input valid, status, slot, run_entry, run_arg, output ready);
endinterface

@@ rtl/ptts_store.sv @@
module ptts_store import ptts_pkg::*; (
   input  logic         clock,
   input  mem_req_type  mem_req,
   output task_rec_type rd_data
);

   task_rec_type task_mem_ff [TASK_SLOTS];
   task_rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         task_mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      rd_data_ff <= task_mem_ff[mem_req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/ptts_seq.sv @@
module ptts_seq import ptts_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   ptts_req_if.sink     req_ch,
   output logic         res_valid,
   input  logic         res_take,
   output rsp_type      res,
   output mem_req_type  mem_req,
   input  task_rec_type rd_data
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [TASK_SLOTS-1:0] valid_ff, valid_in;
   logic [MARK_W-1:0]     mark_ff, mark_in;
   logic [SLOT_W-1:0]     run_slot_ff, run_slot_in;
   logic                  run_known_ff, run_known_in;
   logic [SLOT_W-1:0]     idx_ff, idx_in;
   logic                  pend_ff, pend_in;
   logic [SLOT_W-1:0]     pend_idx_ff, pend_idx_in;
   logic [PRIO_W:0]       best_prio_ff, best_prio_in;
   logic [SLOT_W-1:0]     best_slot_ff, best_slot_in;
   logic [WORD_W-1:0]     best_entry_ff, best_entry_in;
   logic [WORD_W-1:0]     best_arg_ff, best_arg_in;
   rsp_type               res_ff, res_in;

   logic              free_found;
   logic [SLOT_W-1:0] free_slot;
   logic [SLOT_W-1:0] target;
   logic              hit;

   // lowest free slot below the mark
   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i] && (MARK_W'(i) < mark_ff)) begin
            free_found = 1'b1;
            free_slot  = SLOT_W'(i);
         end
      end
   end

   // compare stage runs in the cycle after the memory read
   assign hit = pend_ff && valid_ff[pend_idx_ff]
                && ({1'b0, rd_data.prio} < best_prio_ff);

   always_comb begin
      best_prio_in  = best_prio_ff;
      best_slot_in  = best_slot_ff;
      best_entry_in = best_entry_ff;
      best_arg_in   = best_arg_ff;
      if (hit) begin
         best_prio_in  = {1'b0, rd_data.prio};
         best_slot_in  = pend_idx_ff;
         best_entry_in = rd_data.entry;
         best_arg_in   = rd_data.arg;
      end

      state_in     = state_ff;
      valid_in     = valid_ff;
      mark_in      = mark_ff;
      run_slot_in  = run_slot_ff;
      run_known_in = run_known_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      res_in       = res_ff;
      target       = free_found ? free_slot : mark_ff[SLOT_W-1:0];

      mem_req.wr_en         = 1'b0;
      mem_req.wr_addr       = target;
      mem_req.wr_data.prio  = req_ch.priority_req;
      mem_req.wr_data.entry = req_ch.entry_addr;
      mem_req.wr_data.arg   = req_ch.task_arg;
      mem_req.rd_addr       = idx_ff;

      case (state_ff)
         ST_IDLE: begin
            pend_in      = 1'b0;
            idx_in       = '0;
            best_prio_in = NO_PRIO;
            if (req_ch.valid) begin
               case (req_ch.op)
                  OP_CREATE: begin
                     if (free_found || (mark_ff != MARK_W'(TASK_SLOTS))) begin
                        if (!free_found) begin
                           mark_in = mark_ff + MARK_W'(1);
                        end
                        mem_req.wr_en    = 1'b1;
                        valid_in[target] = 1'b1;
                        res_in           = '0;
                        res_in.status    = STAT_OK;
                        res_in.slot      = SLOT_FIELD_W'(target);
                     end else begin
                        res_in        = '0;
                        res_in.status = STAT_FULL;
                     end
                     state_in = ST_DONE;
                  end
                  OP_EXIT, OP_YIELD: begin
                     if ((req_ch.op == OP_EXIT) && run_known_ff) begin
                        valid_in[run_slot_ff] = 1'b0;
                     end
                     state_in = (mark_ff == '0) ? ST_DRAIN : ST_SCAN;
                  end
                  default: begin
                     res_in   = '0;
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            pend_in     = 1'b1;
            pend_idx_in = idx_ff;
            idx_in      = idx_ff + SLOT_W'(1);
            if ((MARK_W'(idx_ff) + MARK_W'(1)) == mark_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            pend_in = 1'b0;
            res_in  = '0;
            if (best_prio_in == NO_PRIO) begin
               res_in.status = STAT_NONE;
               run_known_in  = 1'b0;
            end else begin
               res_in.status    = STAT_OK;
               res_in.slot      = SLOT_FIELD_W'(best_slot_in);
               res_in.run_entry = best_entry_in;
               res_in.run_arg   = best_arg_in;
               run_slot_in      = best_slot_in;
               run_known_in     = 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         mark_ff      <= '0;
         run_slot_ff  <= '0;
         run_known_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         mark_ff      <= mark_in;
         run_slot_ff  <= run_slot_in;
         run_known_ff <= run_known_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      pend_idx_ff   <= pend_idx_in;
      best_prio_ff  <= best_prio_in;
      best_slot_ff  <= best_slot_in;
      best_entry_ff <= best_entry_in;
      best_arg_ff   <= best_arg_in;
      res_ff        <= res_in;
   end

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign res_valid    = (state_ff == ST_DONE);
   assign res          = res_ff;

endmodule

@@ rtl/priority_task_table_scheduler.sv @@
// Static-priority task table: create, exit and yield requests, one response per request.
// A create moves from the transfer through the DONE state into the output register. Exit and yield
// sweep the task memory one entry per cycle up to the high-water mark, through the single read
// port of the task memory. The next request is taken once the previous response has moved
// into the output register, so a response waiting on the far side does not hold up new work.
// Task records sit in a one-read, one-write memory; writes (create) and the read sweep
// (schedule) belong to different requests and never overlap.
module priority_task_table_scheduler import ptts_pkg::*; (
   input logic         clock,
   input logic         reset,
   ptts_req_if.sink    req_ch,
   ptts_rsp_if.source  rsp_ch
);

   mem_req_type  mem_req;
   task_rec_type rd_data;
   rsp_type      res;
   logic         res_valid;
   logic         res_take;

   logic    rsp_vld_ff, rsp_vld_in;
   rsp_type rsp_data_ff, rsp_data_in;

   ptts_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   ptts_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res       (res),
      .mem_req   (mem_req),
      .rd_data   (rd_data)
   );

   // output register: loads when empty or being drained this cycle
   assign res_take = !rsp_vld_ff || rsp_ch.ready;

   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      rsp_data_in = rsp_data_ff;
      if (res_valid && res_take) begin
         rsp_vld_in  = 1'b1;
         rsp_data_in = res;
      end else if (rsp_ch.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid     = rsp_vld_ff;
   assign rsp_ch.status    = rsp_data_ff.status;
   assign rsp_ch.slot      = rsp_data_ff.slot;
   assign rsp_ch.run_entry = rsp_data_ff.run_entry;
   assign rsp_ch.run_arg   = rsp_data_ff.run_arg;

   a_no_accept_while_pending: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |-> !res_valid)
      else $error("request taken while a response is still pending");

   a_pending_result_holds: assert property (@(posedge clock) disable iff (reset)
      (res_valid && !res_take) |=> (res_valid && $stable(res)))
      else $error("pending response dropped or changed");

   a_error_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && (rsp_data_ff.status != STAT_OK)) |->
      ((rsp_data_ff.slot == '0) && (rsp_data_ff.run_entry == '0)
       && (rsp_data_ff.run_arg == '0)))
      else $error("nonzero fields on a full or empty response");

   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> ((rsp_data_ff.status == STAT_OK) || (rsp_data_ff.status == STAT_FULL)
                      || (rsp_data_ff.status == STAT_NONE)))
      else $error("undefined status code");

endmodule
